[hw/rtl/bva_pkg.sv]
// Types, codes and helpers shared by the bounding volume accumulator modules.
package bva_pkg;

    localparam int unsigned CW         = 24;
    localparam int unsigned OP_W       = 3;
    localparam int unsigned CNT_W      = $clog2(CW);
    localparam int unsigned FIFO_DEPTH = 2;
    localparam int unsigned PTR_W      = $clog2(FIFO_DEPTH);

    localparam logic [OP_W-1:0] OP_POINT  = 3'd0;
    localparam logic [OP_W-1:0] OP_BOX    = 3'd1;
    localparam logic [OP_W-1:0] OP_BOUNDS = 3'd2;
    localparam logic [OP_W-1:0] OP_LOAD   = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;

    typedef struct packed {
        logic [OP_W-1:0]      opcode;
        logic signed [CW-1:0] ax;
        logic signed [CW-1:0] ay;
        logic signed [CW-1:0] az;
        logic signed [CW-1:0] bx;
        logic signed [CW-1:0] by;
        logic signed [CW-1:0] bz;
        logic [CW-1:0]        given_radius;
    } t_in;

    typedef struct packed {
        logic signed [CW-1:0] min_x;
        logic signed [CW-1:0] min_y;
        logic signed [CW-1:0] min_z;
        logic signed [CW-1:0] max_x;
        logic signed [CW-1:0] max_y;
        logic signed [CW-1:0] max_z;
        logic [CW-1:0]        bound_radius;
    } t_out;

    typedef struct packed {
        logic [OP_W-1:0]    op;
        logic [2:0][CW-1:0] a;
        logic [2:0][CW-1:0] b;
        logic [CW-1:0]      gr;
        logic [2:0][CW-1:0] e;
        logic               need_root;
    } t_cmd;

    function automatic logic [CW-1:0] f_abs(logic [CW-1:0] v);
        return v[CW-1] ? CW'(~v + 1'b1) : v;
    endfunction

endpackage

[hw/rtl/bva_front.sv]
// Front end: accepts input beats, decodes the opcode and forms per-axis extents.
module bva_front (
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bva_pkg::t_in  i_in_beat,
    input  logic          i_full,
    output logic          o_push,
    output bva_pkg::t_cmd o_cmd
);
    import bva_pkg::*;

    logic [2:0][CW-1:0] w_a;
    logic [2:0][CW-1:0] w_b;
    logic [CW-1:0]      w_pa;
    logic [CW-1:0]      w_pb;

    assign o_in_ready = !i_full;
    assign o_push     = i_in_valid && !i_full;

    assign w_a = {i_in_beat.az, i_in_beat.ay, i_in_beat.ax};
    assign w_b = {i_in_beat.bz, i_in_beat.by, i_in_beat.bx};

    always_comb begin
        o_cmd.op        = i_in_beat.opcode;
        o_cmd.a         = w_a;
        o_cmd.b         = w_b;
        o_cmd.gr        = i_in_beat.given_radius;
        o_cmd.need_root = (i_in_beat.opcode == OP_POINT) || (i_in_beat.opcode == OP_BOX)
                          || (i_in_beat.opcode == OP_LOAD);
        w_pa = '0;
        w_pb = '0;
        for (int i = 0; i < 3; i++) begin
            w_pa = f_abs(w_a[i]);
            w_pb = f_abs(w_b[i]);
            if (i_in_beat.opcode == OP_POINT || w_pa > w_pb) begin
                o_cmd.e[i] = w_pa;
            end else begin
                o_cmd.e[i] = w_pb;
            end
        end
    end

endmodule

[hw/rtl/bva_fifo.sv]
// Short command queue between the front end and the back end.
module bva_fifo (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  bva_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_empty,
    output bva_pkg::t_cmd o_head
);
    import bva_pkg::*;

    t_cmd             r_mem [FIFO_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [PTR_W:0]   r_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_full    = (r_count == (PTR_W+1)'(FIFO_DEPTH));
    assign o_empty   = (r_count == '0);
    assign o_head    = r_mem[r_rd_ptr];
    assign w_do_push = i_push && !o_full;
    assign w_do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(FIFO_DEPTH-1)) ? '0 : PTR_W'(r_wr_ptr + 1'b1);
            end
            if (w_do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(FIFO_DEPTH-1)) ? '0 : PTR_W'(r_rd_ptr + 1'b1);
            end
            if (w_do_push && !w_do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (w_do_pop && !w_do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[hw/rtl/bva_back.sv]
// Back end: squares, bit-serial root, state merge and output register.
module bva_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  bva_pkg::t_cmd i_head,
    output logic          o_pop,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bva_pkg::t_out o_out_beat
);
    import bva_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SQ   = 2'd1;
    localparam logic [1:0] ST_ROOT = 2'd2;
    localparam logic [1:0] ST_DONE = 2'd3;

    logic [1:0]         r_state;
    t_cmd               r_cmd;
    logic [1:0]         r_axis;
    logic [2*CW-1:0]    r_sum;
    logic [2*CW-1:0]    r_rad;
    logic [CW:0]        r_rem;
    logic [CW-1:0]      r_root;
    logic [CNT_W-1:0]   r_cnt;
    logic [2:0][CW-1:0] r_low;
    logic [2:0][CW-1:0] r_high;
    logic [CW-1:0]      r_radius;
    logic               r_out_valid;
    t_out               r_out;

    logic [2:0][CW-1:0] n_low;
    logic [2:0][CW-1:0] n_high;
    logic [CW-1:0]      n_radius;
    logic [CW-1:0]      w_sq_in;
    logic [2*CW-1:0]    w_prod;
    logic [2*CW-1:0]    w_sum;
    logic [CW+2:0]      w_rem_sh;
    logic [CW+2:0]      w_trial;
    logic               w_take;
    logic               w_commit;
    logic [CW-1:0]      w_lo;
    logic [CW-1:0]      w_hi;

    assign o_pop       = (r_state == ST_IDLE) && !i_empty;
    assign w_commit    = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        unique case (r_axis)
            2'd0:    w_sq_in = r_cmd.e[0];
            2'd1:    w_sq_in = r_cmd.e[1];
            default: w_sq_in = r_cmd.e[2];
        endcase
    end

    assign w_prod   = w_sq_in * w_sq_in;
    assign w_sum    = r_sum + w_prod;
    assign w_rem_sh = {r_rem, r_rad[2*CW-1 -: 2]};
    assign w_trial  = {1'b0, r_root, 2'b01};
    assign w_take   = (w_rem_sh >= w_trial);

    always_comb begin
        n_low    = r_low;
        n_high   = r_high;
        n_radius = r_radius;
        w_lo     = '0;
        w_hi     = '0;
        unique case (r_cmd.op)
            OP_POINT, OP_BOX: begin
                for (int i = 0; i < 3; i++) begin
                    if (r_cmd.op == OP_POINT
                        || $signed(r_cmd.a[i]) < $signed(r_cmd.b[i])) begin
                        w_lo = r_cmd.a[i];
                    end else begin
                        w_lo = r_cmd.b[i];
                    end
                    if (r_cmd.op == OP_POINT
                        || $signed(r_cmd.a[i]) >= $signed(r_cmd.b[i])) begin
                        w_hi = r_cmd.a[i];
                    end else begin
                        w_hi = r_cmd.b[i];
                    end
                    if ($signed(w_lo) < $signed(r_low[i])) begin
                        n_low[i] = w_lo;
                    end
                    if ($signed(w_hi) > $signed(r_high[i])) begin
                        n_high[i] = w_hi;
                    end
                end
                if (r_root > r_radius) begin
                    n_radius = r_root;
                end
            end
            OP_BOUNDS: begin
                for (int i = 0; i < 3; i++) begin
                    if ($signed(r_cmd.a[i]) < $signed(r_low[i])) begin
                        n_low[i] = r_cmd.a[i];
                    end
                    if ($signed(r_cmd.b[i]) > $signed(r_high[i])) begin
                        n_high[i] = r_cmd.b[i];
                    end
                end
                if (r_cmd.gr > r_radius) begin
                    n_radius = r_cmd.gr;
                end
            end
            OP_LOAD: begin
                n_low    = r_cmd.a;
                n_high   = r_cmd.b;
                n_radius = r_root;
            end
            OP_CLEAR: begin
                n_low    = '0;
                n_high   = '0;
                n_radius = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_low       <= '0;
            r_high      <= '0;
            r_radius    <= '0;
        end else begin
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (!i_empty) begin
                        r_state <= i_head.need_root ? ST_SQ : ST_DONE;
                    end
                end
                ST_SQ: begin
                    if (r_axis == 2'd2) begin
                        r_state <= ST_ROOT;
                    end
                end
                ST_ROOT: begin
                    if (r_cnt == '0) begin
                        r_state <= ST_DONE;
                    end
                end
                default: begin
                    if (w_commit) begin
                        r_state     <= ST_IDLE;
                        r_out_valid <= 1'b1;
                        r_low       <= n_low;
                        r_high      <= n_high;
                        r_radius    <= n_radius;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_cmd  <= i_head;
            r_axis <= '0;
            r_sum  <= '0;
            r_root <= '0;
        end
        if (r_state == ST_SQ) begin
            r_axis <= r_axis + 1'b1;
            r_sum  <= w_sum;
            if (r_axis == 2'd2) begin
                r_rad  <= w_sum;
                r_rem  <= '0;
                r_root <= '0;
                r_cnt  <= CNT_W'(CW-1);
            end
        end
        if (r_state == ST_ROOT) begin
            r_rad <= {r_rad[2*CW-3:0], 2'b00};
            r_cnt <= r_cnt - 1'b1;
            if (w_take) begin
                r_rem  <= (CW+1)'(w_rem_sh - w_trial);
                r_root <= {r_root[CW-2:0], 1'b1};
            end else begin
                r_rem  <= (CW+1)'(w_rem_sh);
                r_root <= {r_root[CW-2:0], 1'b0};
            end
        end
        if (w_commit) begin
            r_out.min_x        <= n_low[0];
            r_out.min_y        <= n_low[1];
            r_out.min_z        <= n_low[2];
            r_out.max_x        <= n_high[0];
            r_out.max_y        <= n_high[1];
            r_out.max_z        <= n_high[2];
            r_out.bound_radius <= n_radius;
        end
    end

endmodule

[hw/rtl/bounding_volume_accumulator.sv]
// Bounding volume accumulator top level: front end, command queue, back end.
// Keeps a running axis-aligned box and a radius about the origin (Q12.12) and returns the
// state after every beat. A beat that needs a radius (merge point, merge box, load box)
// pops the queue, forms its three squares in turn on one shared 24x24 multiplier, runs
// the one-bit-per-cycle square root and then merges. Merge bounds, clear and unused
// opcodes only pop the queue and merge. A two-entry queue lets the front end take beats
// while the back end works, and the output register holds a finished result while the
// next beat is computed.
module bounding_volume_accumulator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    input  bva_pkg::t_in  i_in_beat,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output bva_pkg::t_out o_out_beat
);
    import bva_pkg::*;

    t_cmd w_push_cmd;
    t_cmd w_head;
    logic w_push;
    logic w_pop;
    logic w_full;
    logic w_empty;

    bva_front u_front (
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_beat  (i_in_beat),
        .i_full     (w_full),
        .o_push     (w_push),
        .o_cmd      (w_push_cmd)
    );

    bva_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_push_cmd),
        .i_pop   (w_pop),
        .o_full  (w_full),
        .o_empty (w_empty),
        .o_head  (w_head)
    );

    bva_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (w_empty),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_beat  (o_out_beat)
    );

endmodule

[bench/testbench.sv]
// Testbench for the bounding volume accumulator: directed table, random beats, volume predictor.
`timescale 1ns / 100ps

module testbench;
    import bva_pkg::*;

    localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
    localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
    localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

    localparam int ONE = 4096;
    localparam int C_MAX = 8388607;
    localparam int C_MIN = -8388608;
    localparam int R_MAX = 14529495;
    localparam int RAND_BEATS = 1080;
    localparam int TAIL_BEATS = 150;
    localparam int DRAIN_CYCLES = 40;

    typedef struct {
        t_in  beat;
        bit   fixed;
        t_out want;
    } t_dir_row;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic out_ready = 1'b0;
    t_in  in_beat = '0;
    logic in_ready;
    logic out_valid;
    t_out out_beat;

    logic signed [CW-1:0] box_lo [3];
    logic signed [CW-1:0] box_hi [3];
    logic [CW-1:0]        radius;

    t_out     volume_q [$];
    t_dir_row dir_rows [$];
    t_out     want;
    int       errors = 0;
    int       results = 0;
    int       op_cnt [8];
    bit       calm = 1'b0;
    bit       tail = 1'b0;
    int       ready_left = 0;

    bounding_volume_accumulator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_beat   (in_beat),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_beat  (out_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic longint unsigned mag(logic signed [CW-1:0] v);
        longint s;
        s = longint'(v);
        return (s < 0) ? -s : s;
    endfunction

    function automatic logic [CW-1:0] root3(longint unsigned x, longint unsigned y,
                                            longint unsigned z);
        longint unsigned acc;
        longint unsigned r;
        longint unsigned c;
        acc = x * x + y * y + z * z;
        r = 0;
        for (int k = CW; k >= 0; k--) begin
            c = r | (64'd1 << k);
            if (c * c <= acc) r = c;
        end
        return r[CW-1:0];
    endfunction

    task automatic advance_volume(input t_in b, output t_out v);
        logic signed [CW-1:0] pa [3];
        logic signed [CW-1:0] pb [3];
        logic signed [CW-1:0] lo;
        logic signed [CW-1:0] hi;
        longint unsigned      ea [3];
        logic [CW-1:0]        len;
        pa = '{b.ax, b.ay, b.az};
        pb = '{b.bx, b.by, b.bz};
        for (int i = 0; i < 3; i++) begin
            ea[i] = (mag(pa[i]) > mag(pb[i])) ? mag(pa[i]) : mag(pb[i]);
        end
        unique case (b.opcode)
            OP_POINT: begin
                for (int i = 0; i < 3; i++) begin
                    if (pa[i] < box_lo[i]) box_lo[i] = pa[i];
                    if (pa[i] > box_hi[i]) box_hi[i] = pa[i];
                end
                len = root3(mag(pa[0]), mag(pa[1]), mag(pa[2]));
                if (len > radius) radius = len;
            end
            OP_BOX: begin
                for (int i = 0; i < 3; i++) begin
                    lo = (pa[i] < pb[i]) ? pa[i] : pb[i];
                    hi = (pa[i] < pb[i]) ? pb[i] : pa[i];
                    if (lo < box_lo[i]) box_lo[i] = lo;
                    if (hi > box_hi[i]) box_hi[i] = hi;
                end
                len = root3(ea[0], ea[1], ea[2]);
                if (len > radius) radius = len;
            end
            OP_BOUNDS: begin
                for (int i = 0; i < 3; i++) begin
                    if (pa[i] < box_lo[i]) box_lo[i] = pa[i];
                    if (pb[i] > box_hi[i]) box_hi[i] = pb[i];
                end
                if (b.given_radius > radius) radius = b.given_radius;
            end
            OP_LOAD: begin
                box_lo = pa;
                box_hi = pb;
                radius = root3(ea[0], ea[1], ea[2]);
            end
            OP_CLEAR: begin
                box_lo = '{3{'0}};
                box_hi = '{3{'0}};
                radius = '0;
            end
            default: ;
        endcase
        v = '{box_lo[0], box_lo[1], box_lo[2], box_hi[0], box_hi[1], box_hi[2], radius};
    endtask

    function automatic t_in beat(logic [OP_W-1:0] op, int ax, int ay, int az,
                                 int bx, int by, int bz, int gr);
        return '{op, CW'(ax), CW'(ay), CW'(az), CW'(bx), CW'(by), CW'(bz), CW'(gr)};
    endfunction

    function automatic t_out vol(int lx, int ly, int lz, int hx, int hy, int hz, int r);
        return '{CW'(lx), CW'(ly), CW'(lz), CW'(hx), CW'(hy), CW'(hz), CW'(r)};
    endfunction

    task automatic add_row(t_in b, bit fixed, t_out w);
        t_dir_row row;
        row.beat = b;
        row.fixed = fixed;
        row.want = w;
        dir_rows.push_back(row);
    endtask

    function automatic logic signed [CW-1:0] draw_coord();
        unique case ($urandom_range(0, 9))
            0: return CW'(C_MIN);
            1: return CW'(C_MAX);
            2, 3, 4: return CW'($urandom);
            default: return CW'(int'($urandom_range(0, 16 * ONE)) - 8 * ONE);
        endcase
    endfunction

    function automatic t_in draw_beat();
        t_in b;
        int  pick;
        pick = $urandom_range(0, 99);
        if (pick < 40) b.opcode = OP_POINT;
        else if (pick < 62) b.opcode = OP_BOX;
        else if (pick < 78) b.opcode = OP_BOUNDS;
        else if (pick < 88) b.opcode = OP_LOAD;
        else if (pick < 96) b.opcode = OP_CLEAR;
        else b.opcode = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
        b.ax = draw_coord();
        b.ay = draw_coord();
        b.az = draw_coord();
        b.bx = draw_coord();
        b.by = draw_coord();
        b.bz = draw_coord();
        if ($urandom_range(0, 1) != 0) b.given_radius = CW'($urandom_range(0, R_MAX));
        else b.given_radius = CW'($urandom_range(0, 4 * ONE));
        return b;
    endfunction

    // hold the beat until accepted, then predict
    task automatic send_beat(input t_in b, input bit fixed, input t_out w);
        t_out v;
        if (!calm && !tail && $urandom_range(0, 3) == 0) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        in_beat <= b;
        in_valid <= 1'b1;
        do @(posedge i_clk); while (!in_ready);
        advance_volume(b, v);
        volume_q.push_back(fixed ? w : v);
        op_cnt[b.opcode]++;
    endtask

    task automatic check_field(string tag, logic [CW-1:0] w, logic [CW-1:0] g);
        if (w !== g) begin
            $display("%0t %s mismatch: expected %h actual %h", $time, tag, w, g);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && out_ready) begin
            if (volume_q.size() == 0) begin
                $display("%0t unexpected result beat: actual %h", $time, out_beat);
                errors++;
            end else begin
                want = volume_q.pop_front();
                results++;
                check_field("min_x", want.min_x, out_beat.min_x);
                check_field("min_y", want.min_y, out_beat.min_y);
                check_field("min_z", want.min_z, out_beat.min_z);
                check_field("max_x", want.max_x, out_beat.max_x);
                check_field("max_y", want.max_y, out_beat.max_y);
                check_field("max_z", want.max_z, out_beat.max_z);
                check_field("bound_radius", want.bound_radius, out_beat.bound_radius);
            end
        end
        if (tail || calm) begin
            out_ready <= 1'b1;
        end else if (ready_left == 0) begin
            ready_left <= $urandom_range(1, 10);
            out_ready <= ($urandom_range(0, 2) != 0);
        end else begin
            ready_left <= ready_left - 1;
        end
    end

    initial begin
        #5_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        box_lo = '{3{'0}};
        box_hi = '{3{'0}};
        radius = '0;
        foreach (op_cnt[i]) op_cnt[i] = 0;

        add_row(beat(OP_POINT, 0, 0, 0, 0, 0, 0, 0), 1, vol(0, 0, 0, 0, 0, 0, 0));
        add_row(beat(OP_POINT, C_MAX, 0, 0, C_MIN, C_MIN, C_MIN, 0), 1,
                vol(0, 0, 0, C_MAX, 0, 0, C_MAX));
        add_row(beat(OP_POINT, C_MIN, 0, 0, 0, 0, 0, 0), 1,
                vol(C_MIN, 0, 0, C_MAX, 0, 0, 2048 * ONE));
        add_row(beat(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, vol(0, 0, 0, 0, 0, 0, 0));
        add_row(beat(OP_LOAD, C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, 0), 1,
                vol(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX));
        add_row(beat(OP_RSVD5, ONE, -ONE, ONE, -ONE, ONE, -ONE, ONE), 1,
                vol(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX));
        add_row(beat(OP_RSVD6, 0, 0, 0, 0, 0, 0, 0), 0, '0);
        add_row(beat(OP_RSVD7, -1, -1, -1, -1, -1, -1, R_MAX), 0, '0);
        add_row(beat(OP_CLEAR, -1, -1, -1, -1, -1, -1, R_MAX), 1, vol(0, 0, 0, 0, 0, 0, 0));
        add_row(beat(OP_BOUNDS, 0, 0, 0, 0, 0, 0, R_MAX), 1, vol(0, 0, 0, 0, 0, 0, R_MAX));
        add_row(beat(OP_BOUNDS, -5 * ONE, -6 * ONE, -7 * ONE, ONE, 2 * ONE, 3 * ONE, 0), 1,
                vol(-5 * ONE, -6 * ONE, -7 * ONE, ONE, 2 * ONE, 3 * ONE, R_MAX));
        add_row(beat(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, vol(0, 0, 0, 0, 0, 0, 0));
        add_row(beat(OP_BOX, C_MAX, C_MAX, C_MAX, C_MIN, C_MIN, C_MIN, 0), 1,
                vol(C_MIN, C_MIN, C_MIN, C_MAX, C_MAX, C_MAX, R_MAX));
        add_row(beat(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, vol(0, 0, 0, 0, 0, 0, 0));
        add_row(beat(OP_BOX, ONE, 2 * ONE, 3 * ONE, -4 * ONE, 5 * ONE, -6 * ONE, 0), 0, '0);
        add_row(beat(OP_LOAD, 3 * ONE, 3 * ONE, 3 * ONE, -3 * ONE, -3 * ONE, -3 * ONE, 0),
                0, '0);
        add_row(beat(OP_POINT, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0), 0, '0);
        add_row(beat(OP_CLEAR, 0, 0, 0, 0, 0, 0, 0), 1, vol(0, 0, 0, 0, 0, 0, 0));
        add_row(beat(OP_POINT, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 0), 1,
                vol(0, 0, 0, 3 * ONE, 4 * ONE, 0, 5 * ONE));
        add_row(beat(OP_POINT, -1, -1, -1, 0, 0, 0, 0), 0, '0);
        add_row(beat(OP_BOUNDS, 0, 0, 0, 0, 0, 0, 1), 0, '0);
        add_row(beat(OP_POINT, C_MIN, C_MIN, C_MIN, 0, 0, 0, 0), 0, '0);
        add_row(beat(OP_LOAD, 0, 0, 0, 0, 0, 0, 0), 1, vol(0, 0, 0, 0, 0, 0, 0));

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[i]) send_beat(dir_rows[i].beat, dir_rows[i].fixed, dir_rows[i].want);

        for (int k = 0; k < RAND_BEATS; k++) begin
            if (k % 50 == 0) calm = ($urandom_range(0, 3) == 0);
            if (k == RAND_BEATS - TAIL_BEATS) tail = 1'b1;
            // drain the queue once before carrying on
            if (k == 300) begin
                in_valid <= 1'b0;
                do @(posedge i_clk); while (volume_q.size() != 0);
            end
            send_beat(draw_beat(), 0, '0);
        end
        in_valid <= 1'b0;

        do @(posedge i_clk); while (volume_q.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (volume_q.size() != 0) begin
            $display("%0t %0d expected result beats never arrived", $time, volume_q.size());
            errors++;
        end

        $display("%0d directed and %0d random beats sent, %0d result beats checked",
                 dir_rows.size(), RAND_BEATS, results);
        $display("opcodes: point %0d box %0d bounds %0d load %0d clear %0d unused %0d",
                 op_cnt[OP_POINT], op_cnt[OP_BOX], op_cnt[OP_BOUNDS], op_cnt[OP_LOAD],
                 op_cnt[OP_CLEAR], op_cnt[OP_RSVD5] + op_cnt[OP_RSVD6] + op_cnt[OP_RSVD7]);
        if (errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[sim.f]
hw/rtl/bva_pkg.sv
hw/rtl/bva_front.sv
hw/rtl/bva_fifo.sv
hw/rtl/bva_back.sv
hw/rtl/bounding_volume_accumulator.sv
bench/testbench.sv
